### rtl/hhve_pkg.sv
// Shared types and constants for the HTTP header value extractor.
`default_nettype none

package hhve_pkg;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 6;   // value counts and lengths (0..63)
  localparam int MCNT_W    = 5;   // name match count (0..16)
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  // Parameter defaults
  localparam int MAX_VALUE_DEF  = 63;
  localparam int NAME_CHARS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMMA_END  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_EMPTY = 3'd5;

  // Register reset values ("x-forwarded-for:")
  localparam logic [CFG_W-1:0] NAME_LOW_RST  = 64'h7261_776f_7266_2d78;
  localparam logic [CFG_W-1:0] NAME_HIGH_RST = 64'h3a72_6f66_2d64_6564;
  localparam logic [MCNT_W-1:0] NAME_LEN_RST  = 5'd16;
  localparam logic [CNT_W-1:0]  VALUE_LIM_RST = 6'd63;

  // Characters
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

  // Value store write port
  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // Readout request, issued with the final word of a request
  typedef struct packed {
    logic             go;
    logic             found;
    logic [CNT_W-1:0] len;
  } readout_cmd_t;

endpackage

`default_nettype wire

### rtl/hhve_readout.sv
// Value store memory and the readout sequencer with its output register.
`default_nettype none

module hhve_readout #(
  parameter int MAX_VALUE = hhve_pkg::MAX_VALUE_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire hhve_pkg::store_wr_t      wr,
  input  wire hhve_pkg::readout_cmd_t   cmd,
  output logic                          busy,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [hhve_pkg::BYTE_W-1:0]   out_value_byte,
  output logic                          out_found,
  output logic [hhve_pkg::CNT_W-1:0]    out_value_length,
  output logic                          out_last_of_run
);

  localparam int ADDR_W = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;

  logic [hhve_pkg::BYTE_W-1:0] store_mem [MAX_VALUE];

  logic [hhve_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0]           addr_r, addr_nxt;
  logic [hhve_pkg::CNT_W-1:0]  len_r, len_nxt;
  logic                        found_r, found_nxt;
  logic                        empty_r, empty_nxt;
  logic                        rd_v_r, rd_v_nxt;
  logic                        rd_last_r, rd_last_nxt;
  logic [hhve_pkg::BYTE_W-1:0] q_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [hhve_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [hhve_pkg::CNT_W-1:0]  out_len_r, out_len_nxt;
  logic                        out_last_r, out_last_nxt;

  logic out_free;
  logic rd_en;

  // Output register can take a word this cycle
  assign out_free = !out_valid_r || !out_stall;
  // Read one ahead; the read register holds data while the output is stalled
  assign rd_en    = (rem_r != '0) && (!rd_v_r || out_free);
  assign busy     = (rem_r != '0) || rd_v_r || empty_r;

  // Store: one write port from the scanner, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      q_r <= store_mem[addr_r];
    end
  end

  // Sequencer and output register next state
  always_comb begin
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    found_nxt     = found_r;
    empty_nxt     = empty_r;
    rd_v_nxt      = rd_v_r;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_found_nxt = out_found_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    // move read data, or the single not-found / empty word, to the output
    if (rd_v_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = q_r;
      out_found_nxt = 1'b1;
      out_len_nxt   = len_r;
      out_last_nxt  = rd_last_r;
      rd_v_nxt      = 1'b0;
    end else if (empty_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = '0;
      out_found_nxt = found_r;
      out_len_nxt   = '0;
      out_last_nxt  = 1'b1;
      empty_nxt     = 1'b0;
    end

    if (rd_en) begin
      rd_v_nxt    = 1'b1;
      rd_last_nxt = (rem_r == hhve_pkg::CNT_W'(1));
      rem_nxt     = rem_r - hhve_pkg::CNT_W'(1);
      addr_nxt    = addr_r + ADDR_W'(1);
    end

    // new readout; only arrives while idle
    if (cmd.go) begin
      rem_nxt   = cmd.len;
      addr_nxt  = '0;
      len_nxt   = cmd.len;
      found_nxt = cmd.found;
      empty_nxt = (cmd.len == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      empty_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      empty_r     <= empty_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    len_r       <= len_nxt;
    found_r     <= found_nxt;
    rd_last_r   <= rd_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_found_r <= out_found_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value_byte   = out_byte_r;
  assign out_found        = out_found_r;
  assign out_value_length = out_len_r;
  assign out_last_of_run  = out_last_r;

endmodule

`default_nettype wire

### rtl/http_header_value_extractor_unit.sv
// Top level: header name scanner, configuration registers and value readout.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | data_byte, end_of_request
//  out_    | output    | out_valid/out_stall| value_byte, found, value_length, last_of_run
//  cfg_    | input     | cfg_valid/cfg_ready| index, data
//
// Request bytes are taken one per cycle while in_stall is low; the scanner state lives
// in flops and value bytes go straight into the value store.
// After the final byte the store is read out at one word per cycle while out_stall is low
// (N value bytes, or one word when N is 0); in_stall is high until the last word is in the
// output register. A read-ahead register hides the registered store read from the output.
// out_stall only holds the output and read registers; reset is synchronous on rst_n.
`default_nettype none

module http_header_value_extractor_unit #(
  parameter int MAX_VALUE  = hhve_pkg::MAX_VALUE_DEF,
  parameter int NAME_CHARS = hhve_pkg::NAME_CHARS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [hhve_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire                              in_end_of_request,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [hhve_pkg::BYTE_W-1:0]      out_value_byte,
  output logic                             out_found,
  output logic [hhve_pkg::CNT_W-1:0]       out_value_length,
  output logic                             out_last_of_run,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [hhve_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [hhve_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CW = hhve_pkg::CNT_W;
  localparam int MW = hhve_pkg::MCNT_W;

  // Scan phases
  localparam logic [1:0] PH_MATCH  = 2'd0;
  localparam logic [1:0] PH_BLANKS = 2'd1;
  localparam logic [1:0] PH_VALUE  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Configuration registers
  logic [hhve_pkg::CFG_W-1:0] name_low_r, name_high_r;
  logic [MW-1:0]              name_len_r;
  logic [CW-1:0]              value_lim_r;
  logic                       comma_end_r, skip_empty_r;

  // Scanner state
  logic [1:0]    ph_r, ph_nxt;
  logic [MW-1:0] mc_r, mc_nxt;
  logic          mis_r, mis_nxt;
  logic [CW-1:0] sc_r, sc_nxt;
  logic [CW-1:0] nb_r, nb_nxt;

  logic                          in_acc;
  logic                          busy;
  logic [hhve_pkg::BYTE_W-1:0]   b, lc, nc;
  logic [2*hhve_pkg::CFG_W-1:0]  name_chars;
  logic [MW-1:0]                 eff_len, mc_inc;
  logic [CW-1:0]                 eff_lim, sc_inc, nb_new;
  logic                          blank, vb, ok, acc_end;
  hhve_pkg::store_wr_t           wr;
  hhve_pkg::readout_cmd_t        cmd;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_acc    = in_valid && !busy;
  assign b         = in_data_byte;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_low_r   <= hhve_pkg::NAME_LOW_RST;
      name_high_r  <= hhve_pkg::NAME_HIGH_RST;
      name_len_r   <= hhve_pkg::NAME_LEN_RST;
      value_lim_r  <= hhve_pkg::VALUE_LIM_RST;
      comma_end_r  <= 1'b1;
      skip_empty_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        hhve_pkg::REG_NAME_LOW:   name_low_r   <= cfg_data;
        hhve_pkg::REG_NAME_HIGH:  name_high_r  <= cfg_data;
        hhve_pkg::REG_NAME_LEN:   name_len_r   <= cfg_data[MW-1:0];
        hhve_pkg::REG_VALUE_LIM:  value_lim_r  <= cfg_data[CW-1:0];
        hhve_pkg::REG_COMMA_END:  comma_end_r  <= cfg_data[0];
        hhve_pkg::REG_SKIP_EMPTY: skip_empty_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamped name length and value limit
  always_comb begin
    if (name_len_r == '0) begin
      eff_len = MW'(1);
    end else if (name_len_r > MW'(NAME_CHARS)) begin
      eff_len = MW'(NAME_CHARS);
    end else begin
      eff_len = name_len_r;
    end
    if (value_lim_r == '0) begin
      eff_lim = CW'(1);
    end else if (value_lim_r > CW'(MAX_VALUE)) begin
      eff_lim = CW'(MAX_VALUE);
    end else begin
      eff_lim = value_lim_r;
    end
  end

  // Lower-cased byte and the name character due next
  assign lc         = (b >= hhve_pkg::CH_UP_A && b <= hhve_pkg::CH_UP_Z) ?
                      b + hhve_pkg::CASE_OFS : b;
  assign name_chars = {name_high_r, name_low_r};
  assign nc         = name_chars[mc_r[3:0]*hhve_pkg::BYTE_W +: hhve_pkg::BYTE_W];
  assign mc_inc     = mc_r + MW'(1);
  assign sc_inc     = sc_r + CW'(1);
  assign blank      = (b == hhve_pkg::CH_SPACE) || (b == hhve_pkg::CH_TAB);
  assign nb_new     = blank ? nb_r : sc_inc;
  // byte goes to the value path
  assign vb         = ((ph_r == PH_BLANKS) && !blank) || (ph_r == PH_VALUE);

  // Scanner next state
  always_comb begin
    ph_nxt   = ph_r;
    mc_nxt   = mc_r;
    mis_nxt  = mis_r;
    sc_nxt   = sc_r;
    nb_nxt   = nb_r;
    ok       = 1'b0;
    wr.en    = 1'b0;
    wr.addr  = sc_r;
    wr.data  = b;
    cmd.go   = 1'b0;
    cmd.found = 1'b0;
    cmd.len  = '0;
    acc_end  = 1'b0;

    if (in_acc) begin
      // name matching at line start
      if (ph_r == PH_MATCH) begin
        if (b == hhve_pkg::CH_LF) begin
          mc_nxt  = '0;
          mis_nxt = 1'b0;
        end else if (!mis_r) begin
          if (mc_r < MW'(NAME_CHARS) && lc == nc) begin
            mc_nxt = mc_inc;
            if (mc_inc >= eff_len) begin
              ph_nxt = PH_BLANKS;
              sc_nxt = '0;
              nb_nxt = '0;
            end
          end else begin
            mis_nxt = 1'b1;
          end
        end
      end

      // value bytes
      if (vb) begin
        ph_nxt = PH_VALUE;
        if (b == hhve_pkg::CH_LF) begin
          ok = (nb_r != '0) || !skip_empty_r;
          if (ok) begin
            ph_nxt = PH_DONE;
          end else begin
            sc_nxt  = '0;
            nb_nxt  = '0;
            ph_nxt  = PH_MATCH;
            mc_nxt  = '0;
            mis_nxt = 1'b0;
          end
        end else if (b == hhve_pkg::CH_CR ||
                     (b == hhve_pkg::CH_COMMA && comma_end_r)) begin
          ok = (nb_r != '0) || !skip_empty_r;
          if (ok) begin
            ph_nxt = PH_DONE;
          end else begin
            sc_nxt  = '0;
            nb_nxt  = '0;
            ph_nxt  = PH_MATCH;
            mc_nxt  = '0;
            mis_nxt = 1'b1;
          end
        end else if (sc_r < CW'(MAX_VALUE)) begin
          wr.en  = 1'b1;
          sc_nxt = sc_inc;
          nb_nxt = nb_new;
          // limit reached: close the value
          if (sc_inc >= eff_lim) begin
            ok = (nb_new != '0) || !skip_empty_r;
            if (ok) begin
              ph_nxt = PH_DONE;
            end else begin
              sc_nxt  = '0;
              nb_nxt  = '0;
              ph_nxt  = PH_MATCH;
              mc_nxt  = '0;
              mis_nxt = 1'b1;
            end
          end
        end
      end

      // end of request: close an open value, start readout, clear the scan
      if (in_end_of_request) begin
        acc_end   = (ph_nxt == PH_DONE) ||
                    ((ph_nxt == PH_BLANKS || ph_nxt == PH_VALUE) &&
                     ((nb_nxt != '0) || !skip_empty_r));
        cmd.go    = 1'b1;
        cmd.found = acc_end;
        cmd.len   = acc_end ? nb_nxt : '0;
        ph_nxt    = PH_MATCH;
        mc_nxt    = '0;
        mis_nxt   = 1'b0;
        sc_nxt    = '0;
        nb_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_MATCH;
      mc_r  <= '0;
      mis_r <= 1'b0;
      sc_r  <= '0;
      nb_r  <= '0;
    end else begin
      ph_r  <= ph_nxt;
      mc_r  <= mc_nxt;
      mis_r <= mis_nxt;
      sc_r  <= sc_nxt;
      nb_r  <= nb_nxt;
    end
  end

  // Value store and readout
  hhve_readout #(
    .MAX_VALUE(MAX_VALUE)
  ) u_readout (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr              (wr),
    .cmd             (cmd),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value_byte  (out_value_byte),
    .out_found       (out_found),
    .out_value_length(out_value_length),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

### rtl/hhve_checker.sv
// Port-level checks for the header value extractor, bound to the top level.
`default_nettype none

module hhve_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_valid,
  input wire                           in_stall,
  input wire                           in_end_of_request,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire [hhve_pkg::BYTE_W-1:0]    out_value_byte,
  input wire                           out_found,
  input wire [hhve_pkg::CNT_W-1:0]     out_value_length,
  input wire                           out_last_of_run
);

  // The end of a request always starts a readout that holds off input
  a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_request |=> in_stall)
    else $error("input not stalled after end of request");

  // A word that is not the last of its run carries a found, non-empty value
  a_run_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_found && out_value_length != '0)
    else $error("non-final word without a found value");

  // The length stays the same across the words of one run
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      !out_valid || out_value_length == $past(out_value_length))
    else $error("value length changed inside a run");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_byte) &&
      $stable(out_last_of_run))
    else $error("stalled result word changed");

endmodule

bind http_header_value_extractor_unit hhve_checker u_hhve_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_end_of_request(in_end_of_request),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_value_byte   (out_value_byte),
  .out_found        (out_found),
  .out_value_length (out_value_length),
  .out_last_of_run  (out_last_of_run)
);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the header value extractor: directed requests, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hhve_pkg::*;

  localparam int MAXV = MAX_VALUE_DEF;
  localparam int NAMEV = NAME_CHARS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int SETTLE_CYCLES = 8;

  typedef logic [BYTE_W-1:0] octet_t;

  // One result word as seen on the out_ channel
  typedef struct packed {
    octet_t           vbyte;
    logic             found;
    logic [CNT_W-1:0] vlen;
    logic             last;
  } value_word_t;

  typedef enum logic [1:0] {SCAN_NAME, SCAN_BLANKS, SCAN_VALUE, SCAN_DONE} scan_state_e;
  typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_NOT_FOUND, ROW_FOUND_EMPTY} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    string                text;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  octet_t               in_data_byte;
  logic                 in_end_of_request;
  logic                 out_valid;
  logic                 out_stall;
  octet_t               out_value_byte;
  logic                 out_found;
  logic [CNT_W-1:0]     out_value_length;
  logic                 out_last_of_run;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  http_header_value_extractor_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_request (in_end_of_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value_byte    (out_value_byte),
    .out_found         (out_found),
    .out_value_length  (out_value_length),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Mirror of the configuration registers
  logic [CFG_W-1:0]  p_name_lo;
  logic [CFG_W-1:0]  p_name_hi;
  logic [MCNT_W-1:0] p_name_len;
  logic [CNT_W-1:0]  p_value_lim;
  logic              p_comma_end;
  logic              p_skip_empty;

  // Mirror of the scanner state
  scan_state_e scan_state;
  int          name_pos;
  logic        line_skip;
  octet_t      store_mem [0:MAXV-1];
  int          kept_cnt;
  int          nonblank_cnt;
  logic        got_value;

  value_word_t expected_values [$];
  value_word_t fresh_results [$];
  octet_t      req_bytes [$];
  dir_row_t    dir_steps [$];

  bit calm;
  int fail_count;
  int words_sent;
  int words_predicted;
  int words_checked;
  int requests_sent;
  int cfg_writes;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic octet_t name_char(input int i);
    return (i < 8) ? p_name_lo[i*8 +: 8] : p_name_hi[(i-8)*8 +: 8];
  endfunction

  function automatic int eff_name_len();
    int n;
    n = p_name_len;
    if (n < 1) n = 1;
    if (n > NAMEV) n = NAMEV;
    return n;
  endfunction

  function automatic int eff_value_lim();
    int n;
    n = p_value_lim;
    if (n < 1) n = 1;
    if (n > MAXV) n = MAXV;
    return n;
  endfunction

  function automatic void clear_scan();
    scan_state   = SCAN_NAME;
    name_pos     = 0;
    line_skip    = 1'b0;
    kept_cnt     = 0;
    nonblank_cnt = 0;
    got_value    = 1'b0;
  endfunction

  function automatic void line_start(input logic skip);
    scan_state = SCAN_NAME;
    name_pos   = 0;
    line_skip  = skip;
  endfunction

  // Close the value; an empty one is dropped when skip mode is on
  function automatic bit close_value();
    if (nonblank_cnt > 0 || !p_skip_empty) begin
      got_value  = 1'b1;
      scan_state = SCAN_DONE;
      return 1'b1;
    end
    kept_cnt     = 0;
    nonblank_cnt = 0;
    return 1'b0;
  endfunction

  function automatic void value_char(input octet_t b);
    if (b == CH_LF) begin
      if (!close_value()) line_start(1'b0);
      return;
    end
    if (b == CH_CR || (b == CH_COMMA && p_comma_end)) begin
      if (!close_value()) line_start(1'b1);
      return;
    end
    if (kept_cnt < MAXV) begin
      store_mem[kept_cnt] = b;
      kept_cnt++;
      if (b != CH_SPACE && b != CH_TAB) nonblank_cnt = kept_cnt;
    end
    // limit reached: value ends, rest of the line is skipped
    if (kept_cnt >= eff_value_lim()) begin
      if (!close_value()) line_start(1'b1);
    end
  endfunction

  // Advance the scanner by one request byte; fills fresh_results at the end of a request
  function automatic void predict_word(input octet_t b, input logic last);
    octet_t      lo;
    value_word_t w;
    case (scan_state)
      SCAN_NAME: begin
        if (b == CH_LF) begin
          line_start(1'b0);
        end else if (!line_skip) begin
          lo = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
          if (name_pos < NAMEV && lo == name_char(name_pos)) begin
            name_pos++;
            if (name_pos >= eff_name_len()) begin
              scan_state   = SCAN_BLANKS;
              kept_cnt     = 0;
              nonblank_cnt = 0;
            end
          end else begin
            line_skip = 1'b1;
          end
        end
      end
      SCAN_BLANKS: begin
        if (b != CH_SPACE && b != CH_TAB) begin
          scan_state = SCAN_VALUE;
          value_char(b);
        end
      end
      SCAN_VALUE: value_char(b);
      default: ;
    endcase
    if (!last) return;
    if (scan_state == SCAN_BLANKS || scan_state == SCAN_VALUE) void'(close_value());
    if (got_value && nonblank_cnt > 0) begin
      for (int k = 0; k < nonblank_cnt; k++) begin
        w.vbyte = store_mem[k];
        w.found = 1'b1;
        w.vlen  = CNT_W'(nonblank_cnt);
        w.last  = (k + 1 == nonblank_cnt);
        fresh_results.push_back(w);
      end
    end else begin
      w.vbyte = '0;
      w.found = got_value;
      w.vlen  = '0;
      w.last  = 1'b1;
      fresh_results.push_back(w);
    end
    clear_scan();
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_word(input octet_t b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_end_of_request <= last;
    do @(posedge clk); while (in_stall);
    predict_word(b, last);
    words_sent++;
  endtask

  // Send req_bytes as one request; typed rows replace the predicted words
  task automatic send_request(input row_kind_e kind);
    value_word_t w;
    calm = ($urandom_range(0, 3) == 0);
    fresh_results.delete();
    foreach (req_bytes[i]) send_word(req_bytes[i], i == req_bytes.size() - 1);
    case (kind)
      ROW_NOT_FOUND: begin
        w = '{8'h00, 1'b0, '0, 1'b1};
        expected_values.push_back(w);
      end
      ROW_FOUND_EMPTY: begin
        w = '{8'h00, 1'b1, '0, 1'b1};
        expected_values.push_back(w);
      end
      default: foreach (fresh_results[i]) expected_values.push_back(fresh_results[i]);
    endcase
    words_predicted += (kind == ROW_REQ) ? fresh_results.size() : 1;
    requests_sent++;
  endtask

  // Hold the sender until every expected word has come out, then let the block settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NAME_LOW:   p_name_lo    = data;
      REG_NAME_HIGH:  p_name_hi    = data;
      REG_NAME_LEN:   p_name_len   = data[MCNT_W-1:0];
      REG_VALUE_LIM:  p_value_lim  = data[CNT_W-1:0];
      REG_COMMA_END:  p_comma_end  = data[0];
      REG_SKIP_EMPTY: p_skip_empty = data[0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // Random register setting; the phase number walks the extremes
  task automatic random_config(input int phase);
    logic [127:0]      name_bits;
    logic [MCNT_W-1:0] len_reg;
    logic [CNT_W-1:0]  lim_reg;
    int                n;
    string             pool;
    pool = "abcdefghijklmnopqrstuvwxyz0123456789-";
    case (phase % 6)
      0: len_reg = 5'd0;
      1: len_reg = 5'd1;
      2: len_reg = 5'd16;
      3: len_reg = 5'd31;
      default: len_reg = $urandom_range(2, 5);
    endcase
    n = (len_reg < 1) ? 1 : ((len_reg > NAMEV) ? NAMEV : len_reg);
    for (int i = 0; i < NAMEV; i++) name_bits[i*8 +: 8] = pool[$urandom_range(0, pool.len() - 1)];
    if ($urandom_range(0, 1)) name_bits[(n-1)*8 +: 8] = ":";
    // now and then a random byte in place of a name character
    if ($urandom_range(0, 7) == 0) name_bits[$urandom_range(0, n - 1)*8 +: 8] = $urandom_range(0, 255);
    case (phase % 5)
      0: lim_reg = 6'd0;
      1: lim_reg = 6'd1;
      2: lim_reg = 6'd63;
      3: lim_reg = $urandom_range(2, 8);
      default: lim_reg = $urandom_range(9, 63);
    endcase
    cfg_write(REG_NAME_LOW, name_bits[63:0]);
    cfg_write(REG_NAME_HIGH, name_bits[127:64]);
    cfg_write(REG_NAME_LEN, CFG_W'(len_reg));
    cfg_write(REG_VALUE_LIM, CFG_W'(lim_reg));
    cfg_write(REG_COMMA_END, CFG_W'($urandom_range(0, 1)));
    cfg_write(REG_SKIP_EMPTY, CFG_W'($urandom_range(0, 1)));
  endtask

  // Header line for the current name: random case, blanks, value and, mostly, a terminator
  task automatic add_header_line(input bit broken);
    int     n, bad, vlen;
    octet_t c;
    n   = eff_name_len();
    bad = broken ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      c = name_char(i);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - CASE_OFS;
      if (i == bad) c = c ^ octet_t'($urandom_range(1, 255));
      req_bytes.push_back(c);
    end
    repeat ($urandom_range(0, 3)) req_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    vlen = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 6);
    repeat (vlen) begin
      case ($urandom_range(0, 19))
        12, 13:         c = CH_SPACE;
        14:             c = CH_TAB;
        15:             c = CH_COMMA;
        16, 17, 18, 19: c = $urandom_range(0, 255);
        default:        c = $urandom_range(8'h21, 8'h7e);
      endcase
      req_bytes.push_back(c);
    end
    repeat ($urandom_range(0, 2)) req_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(0, 4))
      0: begin
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
      end
      1: req_bytes.push_back(CH_LF);
      2: req_bytes.push_back(CH_CR);
      3: req_bytes.push_back(CH_COMMA);
      default: ;
    endcase
  endtask

  // Mostly well-formed requests; noise lines, broken names and cut-off names mixed in
  task automatic build_request();
    int n, cut;
    req_bytes.delete();
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(0, 6)) req_bytes.push_back(octet_t'($urandom_range(0, 255)));
      req_bytes.push_back(CH_LF);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: add_header_line(1'b0);
      7, 8:                add_header_line(1'b1);
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) add_header_line($urandom_range(0, 3) == 0);
    n = eff_name_len();
    if (n > 1 && $urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, n - 1);
      for (int i = 0; i < cut; i++) req_bytes.push_back(name_char(i));
    end
    if (req_bytes.size() == 0) req_bytes.push_back(octet_t'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------- result side

  // Receiver stall: a random hold before each word
  initial begin
    int gap;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : check_words
    value_word_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_value_byte, out_found, out_value_length, out_last_of_run};
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected word byte=%02h found=%0b len=%0d last=%0b",
                 $time, got.vbyte, got.found, got.vlen, got.last);
        fail_count++;
      end else begin
        want = expected_values.pop_front();
        if (got !== want) begin
          $display("%0t: word mismatch, expected byte=%02h found=%0b len=%0d last=%0b",
                   $time, want.vbyte, want.found, want.vlen, want.last);
          $display("%0t:                 actual byte=%02h found=%0b len=%0d last=%0b",
                   $time, got.vbyte, got.found, got.vlen, got.last);
          fail_count++;
        end
      end
      words_checked++;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase, start_words, start_results;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_data_byte      <= '0;
    in_end_of_request <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    calm = 1'b0;
    p_name_lo    = NAME_LOW_RST;
    p_name_hi    = NAME_HIGH_RST;
    p_name_len   = NAME_LEN_RST;
    p_value_lim  = VALUE_LIM_RST;
    p_comma_end  = 1'b1;
    p_skip_empty = 1'b1;
    clear_scan();

    // Directed rows: reset defaults, limits, blanks, commas, empty values, odd names
    dir_steps.push_back('{ROW_NOT_FOUND, REG_NAME_LOW, '0, "\n"});
    dir_steps.push_back('{ROW_REQ, REG_NAME_LOW, '0, "x-forwarded-for: 1 ,z\n"});
    dir_steps.push_back('{ROW_NOT_FOUND, REG_NAME_LOW, '0, "x-forwarded-fo"});
    dir_steps.push_back('{ROW_CFG, REG_NAME_LOW, 64'h0000_003a_7473_6f68, ""});
    dir_steps.push_back('{ROW_CFG, REG_NAME_HIGH, '1, ""});
    dir_steps.push_back('{ROW_CFG, REG_NAME_LEN, 64'd5, ""});
    dir_steps.push_back('{ROW_REQ, REG_NAME_LOW, '0, "x\nHOST:\t a b \t\r\n"});
    dir_steps.push_back('{ROW_REQ, REG_NAME_LOW, '0, "Host: \t\nhost:v"});
    dir_steps.push_back('{ROW_NOT_FOUND, REG_NAME_LOW, '0, "host: ,x\n"});
    dir_steps.push_back('{ROW_CFG, REG_SKIP_EMPTY, 64'd0, ""});
    dir_steps.push_back('{ROW_FOUND_EMPTY, REG_NAME_LOW, '0, "host: \r\n"});
    dir_steps.push_back('{ROW_NOT_FOUND, REG_NAME_LOW, '0, "hos"});
    dir_steps.push_back('{ROW_CFG, REG_VALUE_LIM, 64'd1, ""});
    dir_steps.push_back('{ROW_REQ, REG_NAME_LOW, '0, "host:abc\n"});
    dir_steps.push_back('{ROW_CFG, REG_VALUE_LIM, 64'd0, ""});
    dir_steps.push_back('{ROW_REQ, REG_NAME_LOW, '0, "hOsT:z"});
    dir_steps.push_back('{ROW_CFG, REG_VALUE_LIM, 64'd63, ""});
    dir_steps.push_back('{ROW_CFG, REG_COMMA_END, 64'd0, ""});
    dir_steps.push_back('{ROW_REQ, REG_NAME_LOW, '0, "host:a,b\n"});
    dir_steps.push_back('{ROW_CFG, REG_NAME_LEN, 64'd0, ""});
    dir_steps.push_back('{ROW_FOUND_EMPTY, REG_NAME_LOW, '0, "h\t"});
    dir_steps.push_back('{ROW_CFG, REG_NAME_LOW, 64'h0a, ""});
    dir_steps.push_back('{ROW_CFG, REG_NAME_LEN, 64'd1, ""});
    dir_steps.push_back('{ROW_NOT_FOUND, REG_NAME_LOW, '0, "\nq\n"});
    dir_steps.push_back('{ROW_CFG, REG_NAME_LOW, 64'h6867_6665_6463_6261, ""});
    dir_steps.push_back('{ROW_CFG, REG_NAME_HIGH, 64'h706f_6e6d_6c6b_6a69, ""});
    dir_steps.push_back('{ROW_CFG, REG_NAME_LEN, 64'd31, ""});
    dir_steps.push_back('{ROW_CFG, REG_SPARE_A, 64'h5a5a_0f0f_3c3c_9696, ""});
    dir_steps.push_back('{ROW_CFG, REG_SPARE_B, '1, ""});
    dir_steps.push_back('{ROW_REQ, REG_NAME_LOW, '0, "ABCDEFGHIJKLMNOPval\r"});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[r]) begin
      if (dir_steps[r].kind == ROW_CFG) begin
        wait_drain();
        cfg_write(dir_steps[r].idx, dir_steps[r].data);
      end else begin
        req_bytes.delete();
        for (int i = 0; i < dir_steps[r].text.len(); i++) req_bytes.push_back(dir_steps[r].text[i]);
        send_request(dir_steps[r].kind);
      end
    end

    // Random part: two requests per register setting
    phase         = 0;
    start_words   = words_sent;
    start_results = words_predicted;
    while (words_sent - start_words < 200 || words_predicted - start_results < 48) begin
      wait_drain();
      random_config(phase);
      for (int k = 0; k < 2; k++) begin
        build_request();
        send_request(ROW_REQ);
        // one mid-setting pause with the pipe drained
        if (phase == 1 && k == 0) wait_drain();
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (MAXV + 10) @(posedge clk);

    $display("Sent %0d requests (%0d bytes) with %0d register writes, %0d random settings",
             requests_sent, words_sent, cfg_writes, phase);
    $display("Checked %0d value words, %0d failures", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
